@@ sv/sfr_pkg.sv @@
`timescale 1ns / 1ps

package sfr_pkg;

  typedef enum logic [1:0] {
    REQ_BYTE = 2'd0,
    REQ_POLL = 2'd1,
    REQ_READ = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_DATA = 2'd1,
    PH_END  = 2'd2
  } phase_t;

  localparam logic REG_FRAME_MODE     = 1'b0;
  localparam logic REG_PAYLOAD_LENGTH = 1'b1;

  localparam logic MODE_BINARY = 1'b0;

  localparam logic [7:0] BIN_START  = 8'hFF;
  localparam logic [7:0] BIN_END    = 8'hFE;
  localparam logic [7:0] TEXT_START = 8'h40;
  localparam logic [7:0] TEXT_CR    = 8'h0D;
  localparam logic [7:0] TEXT_LF    = 8'h0A;

  typedef struct packed {
    logic       en;
    logic [6:0] addr;
    logic [7:0] data;
  } store_wr_t;

  typedef struct packed {
    logic       ready_flag;
    logic [6:0] done_length_next;
  } parse_status_t;

endpackage

@@ sv/sfr_parser.sv @@
`timescale 1ns / 1ps

module sfr_parser #(
  parameter int BUF_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  sfr_pkg::req_t         req_type,
  input  logic [7:0]            rx_byte,
  input  logic                  frame_mode,
  input  logic [6:0]            payload_length,
  output sfr_pkg::store_wr_t    wr,
  output sfr_pkg::parse_status_t status
);
  import sfr_pkg::*;

  localparam int CAP = (BUF_DEPTH < 127) ? BUF_DEPTH : 127;
  localparam logic [6:0] CAP_W = 7'(CAP);

  phase_t     phase;
  phase_t     phase_next;
  logic [6:0] write_count;
  logic [6:0] write_count_next;
  logic       ready_flag;
  logic       ready_flag_next;
  logic [6:0] done_length;
  logic [6:0] done_length_next;

  logic       byte_step;
  logic [6:0] need;
  logic [6:0] count_after;

  assign byte_step = step && (req_type == REQ_BYTE);

  always_comb begin
    if (payload_length == 7'd0) begin
      need = 7'd1;
    end else if (payload_length > CAP_W) begin
      need = CAP_W;
    end else begin
      need = payload_length;
    end
  end

  // Store write for the current byte.
  always_comb begin
    wr.addr = write_count;
    wr.data = rx_byte;
    wr.en   = 1'b0;
    case (phase)
      PH_DATA: begin
        wr.en = byte_step && (write_count < CAP_W) &&
                ((frame_mode == MODE_BINARY) || (rx_byte != TEXT_CR));
      end
      default: begin
        wr.en = 1'b0;
      end
    endcase
  end

  assign count_after = wr.en ? (write_count + 7'd1) : write_count;

  always_comb begin
    phase_next       = phase;
    write_count_next = count_after;
    ready_flag_next  = ready_flag;
    done_length_next = done_length;
    if (step && (req_type == REQ_POLL)) begin
      ready_flag_next = 1'b0;
    end
    if (byte_step) begin
      case (phase)
        PH_DATA: begin
          if (frame_mode == MODE_BINARY) begin
            if (count_after >= need) begin
              phase_next = PH_END;
            end
          end else if (rx_byte == TEXT_CR) begin
            phase_next = PH_END;
          end
        end
        PH_END: begin
          if (((frame_mode == MODE_BINARY) && (rx_byte == BIN_END)) ||
              ((frame_mode != MODE_BINARY) && (rx_byte == TEXT_LF))) begin
            phase_next       = PH_WAIT;
            ready_flag_next  = 1'b1;
            done_length_next = write_count;
          end
        end
        default: begin
          phase_next = PH_WAIT;
          if (((frame_mode == MODE_BINARY) && (rx_byte == BIN_START)) ||
              ((frame_mode != MODE_BINARY) && (rx_byte == TEXT_START) && !ready_flag)) begin
            phase_next       = PH_DATA;
            write_count_next = 7'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_WAIT;
      write_count <= 7'd0;
      ready_flag  <= 1'b0;
      done_length <= 7'd0;
    end else begin
      phase       <= phase_next;
      write_count <= write_count_next;
      ready_flag  <= ready_flag_next;
      done_length <= done_length_next;
    end
  end

  assign status.ready_flag       = ready_flag;
  assign status.done_length_next = done_length_next;

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    write_count <= CAP_W)
    else $error("write count beyond capacity");

  a_write_advances: assert property (@(posedge clk) disable iff (rst)
    wr.en |=> write_count == $past(write_count) + 7'd1)
    else $error("store write did not advance the count");

  a_flag_from_end: assert property (@(posedge clk) disable iff (rst)
    $rose(ready_flag) |-> $past(phase) == PH_END)
    else $error("ready flag set outside the end marker phase");

  a_frame_starts_empty: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA && $past(phase) == PH_WAIT) |-> write_count == 7'd0)
    else $error("frame started with a nonzero count");

endmodule

@@ sv/serial_frame_receiver.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Contents
// s_*       in         tuser: req_type; tdata: rx_byte, read_index
// m_*       out        tdata: frame_ready, frame_length, read_data
// apb       in/out     frame_mode at 0x0, payload_length at 0x4
//
// One transaction per cycle unless backpressure stalls; each result is registered the cycle after its input.
// The frame state and the store are updated at the input handshake edge.
// The output register holds a result under backpressure while s_tready
// follows m_tready. Reset is synchronous; the store needs no clearing.

module serial_frame_receiver #(
  parameter int BUF_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] rx_byte, [13:8] read_index, [15:14] zero
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] frame_ready, [7:1] frame_length, [15:8] read_data
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sfr_pkg::*;

  localparam int AW = $clog2(BUF_DEPTH);

  logic          frame_mode;
  logic [6:0]    payload_length;
  logic          cfg_we;

  req_t          req_type;
  logic [7:0]    rx_byte;
  logic [5:0]    read_index;
  logic          accept;

  store_wr_t     wr;
  parse_status_t status;

  logic [7:0]    store [BUF_DEPTH];
  logic [7:0]    rd_q;
  logic          rd_en_q;
  logic          rdy_q;
  logic [6:0]    len_q;

  assign req_type   = req_t'(s_tuser);
  assign rx_byte    = s_tdata[7:0];
  assign read_index = s_tdata[13:8];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mode     <= 1'b0;
      payload_length <= 7'd8;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_FRAME_MODE:     frame_mode     <= pwdata[0];
        REG_PAYLOAD_LENGTH: payload_length <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_MODE:     prdata = {31'd0, frame_mode};
      REG_PAYLOAD_LENGTH: prdata = {25'd0, payload_length};
      default:            prdata = 32'd0;
    endcase
  end

  sfr_parser #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_parser (
    .clk            (clk),
    .rst            (rst),
    .step           (accept),
    .req_type       (req_type),
    .rx_byte        (rx_byte),
    .frame_mode     (frame_mode),
    .payload_length (payload_length),
    .wr             (wr),
    .status         (status)
  );

  always_ff @(posedge clk) begin
    if (wr.en) begin
      store[AW'(wr.addr)] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q <= store[AW'(read_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdy_q   <= (req_type == REQ_POLL) && status.ready_flag;
      len_q   <= status.done_length_next;
      rd_en_q <= (req_type == REQ_READ) && (32'(read_index) < BUF_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {(rd_en_q ? rd_q : 8'h00), len_q, rdy_q};

endmodule
